// ===== rtl/addressed_command_frame_responder_core_assert.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ADDRESSED_COMMAND_FRAME_RESPONDER_CORE_ASSERT_SVH
`define ADDRESSED_COMMAND_FRAME_RESPONDER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACFR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acfr_pkg.sv =====
package acfr_pkg;

    // operation codes carried in the slave-side tuser
    localparam logic [1:0] OP_RX_BYTE      = 2'd0;
    localparam logic [1:0] OP_ENV_UPDATE   = 2'd1;
    localparam logic [1:0] OP_MOTOR_UPDATE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_OWN_ADDRESS    = 2'd0;
    localparam logic [1:0] CFG_REPLY_ID       = 2'd1;
    localparam logic [1:0] CFG_SPEED_VALUE    = 2'd2;
    localparam logic [1:0] CFG_SETPOINT_VALUE = 2'd3;

    localparam logic [7:0] PREAMBLE_0 = 8'hAA;
    localparam logic [7:0] PREAMBLE_1 = 8'h00;
    localparam logic [7:0] PREAMBLE_2 = 8'hFF;
    localparam logic [3:0] CMD_STATUS = 4'h0;

    localparam int         IDX_W      = 5;
    localparam logic [4:0] FRAME_LAST = 5'd19;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    typedef struct packed {
        logic [3:0] own_address;
        logic [7:0] reply_id;
        logic [7:0] speed_value;
        logic [7:0] setpoint_value;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        own_address:    4'd10,
        reply_id:       8'd10,
        speed_value:    8'd80,
        setpoint_value: 8'd90
    };

    // sensor values captured when a status request is decoded
    typedef struct packed {
        logic [31:0] env_temp;
        logic [31:0] env_pressure;
        logic [31:0] env_humidity;
        logic [15:0] motor_temp;
    } snapshot_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ===== rtl/addressed_command_frame_responder_core.sv =====
// Addressed command frame responder.
// Slave side: one request per cycle; tuser holds the operation (received byte,
// environment update, motor temperature update), tdata the payload fields.
// Received bytes are parsed for the preamble AA 00 FF, a target/command byte
// and a data byte; a status command to our address queues a 20-byte reply.
// Master side: reply bytes in tdata, tlast on the twentieth byte.
// Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready;
// write only while the block is idle.
// When the data byte that triggers a reply is accepted, the reply goes into the
// queue and then its first byte into the output register, which drives the
// master side; the rest follow one per cycle while m_axis_tready is high.
// A reply is 20 bytes, produced by the byte serializer in the back end. Sensor
// values are captured at trigger time.
// Input throughput is one request per cycle; s_axis_tready drops only while
// QUEUE_DEPTH replies are pending, so a stalled receiver backs up the input.
// Reset clears the parser to hunting, stored readings to zero, the queue and
// the output valid flag, and loads the register defaults (address 10, reply id
// 10, speed 80, setpoint 90).
module addressed_command_frame_responder_core
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // rx_byte[7:0], env_temp[39:8], env_pressure[71:40], env_humidity[103:72],
    // motor_temp[119:104]
    input  logic [acfr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [acfr_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tx_byte[7:0]
    output logic [7:0]                     m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [acfr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [acfr_pkg::CFG_DAT_W-1:0] cfg_data
);

    acfr_pkg::cfg_t          cfg_reg;
    acfr_pkg::queue_status_t q_status;
    acfr_pkg::snapshot_t     push_data;
    acfr_pkg::snapshot_t     head;
    logic                    push;
    logic                    pop;

    assign cfg_ready = 1'b1;

    // hold the register bank; a write takes effect at the handshake edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= acfr_pkg::CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                acfr_pkg::CFG_OWN_ADDRESS:    cfg_reg.own_address    <= cfg_data[3:0];
                acfr_pkg::CFG_REPLY_ID:       cfg_reg.reply_id       <= cfg_data;
                acfr_pkg::CFG_SPEED_VALUE:    cfg_reg.speed_value    <= cfg_data;
                acfr_pkg::CFG_SETPOINT_VALUE: cfg_reg.setpoint_value <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // parse requests, keep the latest readings, push a snapshot per reply
    acfr_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .operation   (s_axis_tuser),
        .item_data   (s_axis_tdata),
        .own_address (cfg_reg.own_address),
        .q_status    (q_status),
        .push        (push),
        .snapshot    (push_data)
    );

    // pending replies between parser and serializer
    acfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // advance through the 20 reply bytes of the head entry
    acfr_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .cfg      (cfg_reg),
        .pop      (pop),
        .tx_valid (m_axis_tvalid),
        .tx_ready (m_axis_tready),
        .tx_byte  (m_axis_tdata),
        .tx_last  (m_axis_tlast)
    );

endmodule

// ===== rtl/acfr_front.sv =====
module acfr_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic [1:0]                    operation,
    input  logic [acfr_pkg::S_TDATA_W-1:0] item_data,
    input  logic [3:0]                    own_address,
    input  acfr_pkg::queue_status_t       q_status,
    output logic                          push,
    output acfr_pkg::snapshot_t           snapshot
);

    typedef enum logic [2:0] {
        HUNT_AA  = 3'd0,
        HUNT_00  = 3'd1,
        HUNT_FF  = 3'd2,
        GET_CMD  = 3'd3,
        GET_DATA = 3'd4
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [3:0]          target_reg, target_next;
    logic [3:0]          command_reg, command_next;
    acfr_pkg::snapshot_t snap_reg, snap_next;
    logic                accept;
    logic [7:0]          rx_byte;

    assign item_ready = !q_status.full;
    assign accept     = item_valid && item_ready;
    assign rx_byte    = item_data[7:0];
    assign snapshot   = snap_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        target_next  = target_reg;
        command_next = command_reg;
        snap_next    = snap_reg;
        push         = 1'b0;
        if (accept)
        begin
            unique case (operation)
                acfr_pkg::OP_RX_BYTE:
                begin
                    unique case (phase_reg)
                        HUNT_AA:
                        begin
                            if (rx_byte == acfr_pkg::PREAMBLE_0)
                            begin
                                phase_next = HUNT_00;
                            end
                        end
                        HUNT_00:
                        begin
                            phase_next = (rx_byte == acfr_pkg::PREAMBLE_1) ? HUNT_FF : HUNT_AA;
                        end
                        HUNT_FF:
                        begin
                            phase_next = (rx_byte == acfr_pkg::PREAMBLE_2) ? GET_CMD : HUNT_AA;
                        end
                        GET_CMD:
                        begin
                            command_next = rx_byte[3:0];
                            target_next  = rx_byte[7:4];
                            phase_next   = GET_DATA;
                        end
                        GET_DATA:
                        begin
                            // data byte value is ignored
                            phase_next = HUNT_AA;
                            push       = (target_reg == own_address) &&
                                         (command_reg == acfr_pkg::CMD_STATUS);
                        end
                        default:
                        begin
                            phase_next = HUNT_AA;
                        end
                    endcase
                end
                acfr_pkg::OP_ENV_UPDATE:
                begin
                    snap_next.env_temp     = item_data[39:8];
                    snap_next.env_pressure = item_data[71:40];
                    snap_next.env_humidity = item_data[103:72];
                end
                acfr_pkg::OP_MOTOR_UPDATE:
                begin
                    snap_next.motor_temp = item_data[119:104];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= HUNT_AA;
            target_reg  <= 4'hF;
            command_reg <= 4'hF;
            snap_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            target_reg  <= target_next;
            command_reg <= command_next;
            snap_reg    <= snap_next;
        end
    end

endmodule

// ===== rtl/acfr_queue.sv =====
`include "addressed_command_frame_responder_core_assert.svh"

module acfr_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  acfr_pkg::snapshot_t     push_data,
    input  logic                    pop,
    output acfr_pkg::snapshot_t     head,
    output acfr_pkg::queue_status_t status
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    acfr_pkg::snapshot_t entries [DEPTH];
    logic [PW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;

    assign head         = entries[rd_ptr_reg];
    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `ACFR_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !status.full, "push into full queue")
    `ACFR_ASSERT_IMPLY(a_no_pop_empty, clk, rst_n, pop, !status.empty, "pop from empty queue")
    `ACFR_ASSERT_NEXT(a_count_up, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1, "count did not advance on push")

endmodule

// ===== rtl/acfr_back.sv =====
`include "addressed_command_frame_responder_core_assert.svh"

module acfr_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  acfr_pkg::snapshot_t     head,
    input  acfr_pkg::queue_status_t q_status,
    input  acfr_pkg::cfg_t          cfg,
    output logic                    pop,
    output logic                    tx_valid,
    input  logic                    tx_ready,
    output logic [7:0]              tx_byte,
    output logic                    tx_last
);

    logic [acfr_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [7:0]                 byte_reg, byte_next;
    logic                       last_reg, last_next;
    logic                       load;

    function automatic logic [7:0] frame_byte(
        input logic [acfr_pkg::IDX_W-1:0] idx,
        input acfr_pkg::snapshot_t        s,
        input acfr_pkg::cfg_t             c
    );
        logic [7:0] b;
        case (idx)
            5'd0:    b = acfr_pkg::PREAMBLE_0;
            5'd1:    b = acfr_pkg::PREAMBLE_1;
            5'd2:    b = acfr_pkg::PREAMBLE_2;
            5'd3:    b = c.reply_id;
            5'd4:    b = s.env_temp[7:0];
            5'd5:    b = s.env_temp[15:8];
            5'd6:    b = s.env_temp[23:16];
            5'd7:    b = s.env_temp[31:24];
            5'd8:    b = s.env_pressure[7:0];
            5'd9:    b = s.env_pressure[15:8];
            5'd10:   b = s.env_pressure[23:16];
            5'd11:   b = s.env_pressure[31:24];
            5'd12:   b = s.env_humidity[7:0];
            5'd13:   b = s.env_humidity[15:8];
            5'd14:   b = s.env_humidity[23:16];
            5'd15:   b = s.env_humidity[31:24];
            5'd16:   b = s.motor_temp[7:0];
            5'd17:   b = s.motor_temp[15:8];
            5'd18:   b = c.speed_value;
            5'd19:   b = c.setpoint_value;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // refill the output register from a non-empty queue whenever it is empty or being taken
    assign load = !q_status.empty && (!valid_reg || tx_ready);
    assign pop  = load && (idx_reg == acfr_pkg::FRAME_LAST);

    assign tx_valid = valid_reg;
    assign tx_byte  = byte_reg;
    assign tx_last  = last_reg;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = frame_byte(idx_reg, head, cfg);
            last_next  = (idx_reg == acfr_pkg::FRAME_LAST);
            idx_next   = (idx_reg == acfr_pkg::FRAME_LAST) ? '0 : idx_reg + 1'b1;
        end
        else if (tx_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    `ACFR_ASSERT_IMPLY(a_last_wraps, clk, rst_n, valid_reg && last_reg, idx_reg == '0, "frame index not wrapped after last byte")

endmodule
